// ===== src/keyframed_velocity_path_stepper_unit_defines.svh =====
// assertion macros for the keyframed velocity path stepper
`ifndef KEYFRAMED_VELOCITY_PATH_STEPPER_UNIT_DEFINES_SVH
`define KEYFRAMED_VELOCITY_PATH_STEPPER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KVPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KVPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kvps_pkg.sv =====
// shared types and constants of the keyframed velocity path stepper
package kvps_pkg;

    localparam int PROD_W = 42;
    localparam int NUM_W  = 25;
    localparam int DIFF_W = 17;
    localparam int DIV_DW = 16;
    localparam int DIV_QW = 17;

    localparam logic [15:0] ONE_Q88 = 16'd256;

    localparam logic [1:0] CFG_FRAME_COUNT   = 2'd0;
    localparam logic [1:0] CFG_LOOP_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_TICK_INTERVAL = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_SET     = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEL,
        S_RDF,
        S_RDN,
        S_MUL,
        S_DST,
        S_DWT,
        S_VEL,
        S_PMUL,
        S_PADD,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== src/keyframed_velocity_path_stepper_unit.sv =====
// keyframed velocity path stepper, top level
// usage:
//   slave stream carries one command per transaction: tuser holds the command
//   (load frame, restart, tick, set position), tdata the keyframe slot,
//   velocity, duration and the observer or new position
//   master stream returns one result per command: position minus observer,
//   the frame in effect and the interpolated velocity (zeros but the frame
//   for commands other than tick)
//   configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
//   only while the block is idle, a rule for the user that the block
//   does not enforce; there is no read-back
// sequencing:
//   a tick runs its steps on one 25x17 multiplier and one 17-step serial
//   divider shared by both axes (per axis: multiply, divide, velocity,
//   multiply, add); other commands go straight to the done state; a new
//   command is taken only after the result has moved to the output
//   register, so commands do not overlap
// reset: synchronous active low; clears position, time, frame pointer and
//   loads frame count 1, no loop, tick interval 1.0; keyframe slots are
//   undefined until loaded
// stall: the result waits in the output register and the next command is
//   still taken; a finished command holds until the register frees
module keyframed_velocity_path_stepper_unit
    import kvps_pkg::*;
#(
    parameter int MAX_FRAMES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: frame_index[3:0], key_vel_x[19:4], key_vel_y[35:20],
    //        key_duration[51:36], coord_x[83:52], coord_y[115:84]
    input  logic [119:0] i_s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]   i_s_tuser,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: rel_x[31:0], rel_y[63:32], current_frame[67:64],
    //        cur_vel_x[83:68], cur_vel_y[99:84]
    output logic [103:0] o_m_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_wdata
);

`include "keyframed_velocity_path_stepper_unit_defines.svh"

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = AW + 1;

    t_state n_state;
    t_state r_state;

    logic [4:0]  r_frame_count;
    logic        r_loop;
    logic [15:0] r_interval;

    logic [15:0] mem_vx  [MAX_FRAMES];
    logic [15:0] mem_vy  [MAX_FRAMES];
    logic [15:0] mem_dur [MAX_FRAMES];
    logic [15:0] r_rd_vx;
    logic [15:0] r_rd_vy;
    logic [15:0] r_rd_dur;

    logic [AW-1:0]      r_fp;
    logic               r_fvalid;
    logic               r_adv;
    logic               r_hold;
    logic signed [23:0] r_tl;
    logic signed [31:0] r_posx;
    logic signed [31:0] r_posy;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic signed [15:0] r_v0x;
    logic signed [15:0] r_v0y;
    logic [15:0]        r_dur;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [PROD_W-1:0] r_prod;
    logic               r_comp;
    logic signed [15:0] r_velx;
    logic signed [15:0] r_vely;
    logic signed [31:0] r_relx;
    logic signed [31:0] r_rely;

    logic               r_out_valid;
    logic signed [31:0] r_o_relx;
    logic signed [31:0] r_o_rely;
    logic [3:0]         r_o_frame;
    logic signed [15:0] r_o_velx;
    logic signed [15:0] r_o_vely;

    logic        w_acc;
    t_cmd        w_cmd_in;
    logic [3:0]  w_idx_in;
    logic        w_idx_ok;
    logic        w_s_ready;
    logic        w_div_start;
    logic        w_load_out;
    logic [AW-1:0] w_rd_addr;
    logic signed [NUM_W-1:0]  w_ma;
    logic signed [DIFF_W-1:0] w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_mag;
    t_div_stat   w_div_stat;
    logic [DIV_QW:0] w_quo;

    logic [CW-1:0] w_cnt;
    logic [CW-1:0] w_inc;
    logic [CW-1:0] w_fp_p1;
    logic [AW-1:0] w_nfp;
    logic [AW-1:0] w_nxt;
    logic          w_adv;
    logic          w_last;
    logic          w_hold;
    logic [15:0]   w_dur_eff;

    logic signed [15:0] w_v0;
    logic signed [18:0] w_sq;
    logic signed [19:0] w_vsum;
    logic signed [15:0] w_vsat;
    logic signed [31:0] w_pos;
    logic signed [33:0] w_padd;
    logic signed [24:0] w_tsub;
    logic signed [23:0] w_tsat;
    logic signed [33:0] w_rdx;
    logic signed [33:0] w_rdy;

    function automatic logic signed [31:0] f_sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            res = v[31:0];
        end else begin
            res = v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return res;
    endfunction

    assign w_acc    = i_s_tvalid && o_s_tready;
    assign w_cmd_in = t_cmd'(i_s_tuser[1:0]);
    assign w_idx_in = i_s_tdata[3:0];
    assign w_idx_ok = 32'(w_idx_in) < 32'(MAX_FRAMES);

    // frame bookkeeping
    always_comb begin
        if (r_frame_count == 5'd0) begin
            w_cnt = CW'(1);
        end else if (32'(r_frame_count) > 32'(MAX_FRAMES)) begin
            w_cnt = CW'(MAX_FRAMES);
        end else begin
            w_cnt = CW'(r_frame_count);
        end
        w_inc   = r_fvalid ? ({1'b0, r_fp} + CW'(1)) : '0;
        if (w_inc >= w_cnt) begin
            w_nfp = r_loop ? '0 : AW'(w_cnt - CW'(1));
        end else begin
            w_nfp = AW'(w_inc);
        end
        w_fp_p1   = {1'b0, r_fp} + CW'(1);
        w_last    = w_fp_p1 >= w_cnt;
        w_hold    = w_last && !r_loop;
        w_nxt     = w_last ? '0 : AW'(w_fp_p1);
        w_adv     = r_tl <= 24'sd0;
        w_dur_eff = w_hold ? ONE_Q88 : ((r_rd_dur == 16'd0) ? 16'd1 : r_rd_dur);
    end

    // arithmetic datapath
    always_comb begin
        w_prod = w_ma * w_mb;
        w_mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_v0   = r_comp ? r_v0y : r_v0x;
        w_sq   = r_prod[PROD_W-1] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        w_vsum = {{4{w_v0[15]}}, w_v0} + {w_sq[18], w_sq};
        if (w_vsum[19:15] == 5'b00000 || w_vsum[19:15] == 5'b11111) begin
            w_vsat = w_vsum[15:0];
        end else begin
            w_vsat = w_vsum[19] ? 16'sh8000 : 16'sh7fff;
        end
        w_pos  = r_comp ? r_posy : r_posx;
        w_padd = {{2{w_pos[31]}}, w_pos} + {r_prod[32], r_prod[32:0]};
        w_tsub = {r_tl[23], r_tl} - {9'b0, r_interval};
        w_tsat = (w_tsub[24] == w_tsub[23]) ? w_tsub[23:0] : 24'sh80_0000;
        w_rdx  = {{2{r_posx[31]}}, r_posx} - {{2{r_cx[31]}}, r_cx};
        w_rdy  = {{2{r_posy[31]}}, r_posy} - {{2{r_cy[31]}}, r_cy};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (w_cmd_in == CMD_TICK) ? S_SEL : S_DONE;
                end
            end
            S_SEL:  n_state = S_RDF;
            S_RDF:  n_state = S_RDN;
            S_RDN:  n_state = S_MUL;
            S_MUL:  n_state = S_DST;
            S_DST:  n_state = S_DWT;
            S_DWT:  n_state = w_div_stat.done ? S_VEL : S_DWT;
            S_VEL:  n_state = S_PMUL;
            S_PMUL: n_state = S_PADD;
            S_PADD: n_state = r_comp ? S_FIN : S_MUL;
            S_FIN:  n_state = S_DONE;
            S_DONE: n_state = (!r_out_valid || i_m_tready) ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        w_s_ready   = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        w_rd_addr   = r_fp;
        w_ma        = r_num;
        w_mb        = r_comp ? r_dy : r_dx;
        case (r_state)
            S_IDLE: w_s_ready = 1'b1;
            S_SEL:  w_rd_addr = w_adv ? w_nfp : r_fp;
            S_RDF:  w_rd_addr = w_nxt;
            S_DST:  w_div_start = 1'b1;
            S_PMUL: begin
                w_ma = {9'b0, r_interval};
                w_mb = r_comp ? {r_vely[15], r_vely} : {r_velx[15], r_velx};
            end
            S_DONE: w_load_out = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    assign o_s_tready = w_s_ready;

    kvps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (w_mag),
        .i_dvs   (r_dur),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo)
    );

    // keyframe tables
    always_ff @(posedge i_clk) begin
        if (w_acc && w_cmd_in == CMD_LOAD && w_idx_ok) begin
            mem_vx[AW'(w_idx_in)]  <= i_s_tdata[19:4];
            mem_vy[AW'(w_idx_in)]  <= i_s_tdata[35:20];
            mem_dur[AW'(w_idx_in)] <= i_s_tdata[51:36];
        end
        r_rd_vx  <= mem_vx[w_rd_addr];
        r_rd_vy  <= mem_vy[w_rd_addr];
        r_rd_dur <= mem_dur[w_rd_addr];
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= 5'd1;
            r_loop        <= 1'b0;
            r_interval    <= ONE_Q88;
            r_fp          <= '0;
            r_fvalid      <= 1'b0;
            r_tl          <= '0;
            r_posx        <= '0;
            r_posy        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT:   r_frame_count <= i_cfg_wdata[4:0];
                    CFG_LOOP_ENABLE:   r_loop        <= i_cfg_wdata[0];
                    CFG_TICK_INTERVAL: r_interval    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_acc && w_cmd_in == CMD_RESTART) begin
                r_fp     <= '0;
                r_fvalid <= 1'b0;
                r_tl     <= '0;
            end
            if (w_acc && w_cmd_in == CMD_SET) begin
                r_posx <= i_s_tdata[83:52];
                r_posy <= i_s_tdata[115:84];
            end
            if (r_state == S_SEL && w_adv) begin
                r_fp     <= w_nfp;
                r_fvalid <= 1'b1;
            end
            if (r_state == S_RDF && r_adv) begin
                r_tl <= r_tl + {8'b0, (w_hold ? ONE_Q88 : r_rd_dur)};
            end
            if (r_state == S_PADD) begin
                if (r_comp) begin
                    r_posy <= f_sat32(w_padd);
                end else begin
                    r_posx <= f_sat32(w_padd);
                end
            end
            if (r_state == S_FIN) begin
                r_tl <= w_tsat;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cx   <= i_s_tdata[83:52];
            r_cy   <= i_s_tdata[115:84];
            r_velx <= '0;
            r_vely <= '0;
            r_relx <= '0;
            r_rely <= '0;
            r_comp <= 1'b0;
        end
        if (r_state == S_SEL) begin
            r_adv <= w_adv;
        end
        if (r_state == S_RDF) begin
            r_v0x  <= r_rd_vx;
            r_v0y  <= r_rd_vy;
            r_dur  <= w_dur_eff;
            r_hold <= w_hold;
        end
        if (r_state == S_RDN) begin
            r_num <= {9'b0, r_dur} - {r_tl[23], r_tl};
            r_dx  <= r_hold ? '0 : ({r_rd_vx[15], r_rd_vx} - {r_v0x[15], r_v0x});
            r_dy  <= r_hold ? '0 : ({r_rd_vy[15], r_rd_vy} - {r_v0y[15], r_v0y});
        end
        if (r_state == S_MUL || r_state == S_PMUL) begin
            r_prod <= w_prod;
        end
        if (r_state == S_VEL) begin
            if (r_comp) begin
                r_vely <= w_vsat;
            end else begin
                r_velx <= w_vsat;
            end
        end
        if (r_state == S_PADD) begin
            r_comp <= 1'b1;
        end
        if (r_state == S_FIN) begin
            r_relx <= f_sat32(w_rdx);
            r_rely <= f_sat32(w_rdy);
        end
        if (w_load_out) begin
            r_o_relx  <= r_relx;
            r_o_rely  <= r_rely;
            r_o_frame <= r_fvalid ? 4'(r_fp) : 4'd0;
            r_o_velx  <= r_velx;
            r_o_vely  <= r_vely;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_o_vely, r_o_velx, r_o_frame, r_o_rely, r_o_relx};

    `KVPS_ASSERT_NXT(a_busy_after_accept, w_acc, r_state != S_IDLE,
        "block still ready after taking a command")
    `KVPS_ASSERT_IMP(a_div_start_idle, w_div_start, !w_div_stat.busy,
        "divider restarted while busy")
    `KVPS_ASSERT_IMP(a_time_bound, 1'b1, !(r_tl > 24'sd65535),
        "remaining time above the largest duration")
    `KVPS_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE),
        "result shown without a finished command")

endmodule

// ===== src/kvps_div.sv =====
// serial restoring divider with quotient clamp for velocity interpolation
module kvps_div
    import kvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_mag,
    input  logic [DIV_DW-1:0] i_dvs,
    output t_div_stat         o_stat,
    output logic [DIV_QW:0]   o_quo
);

    localparam int CNT_W = $clog2(DIV_QW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_QW-1:0] r_low;
    logic [DIV_DW:0]   w_sh;
    logic              w_ge;
    logic [DIV_DW:0]   w_diff;

    assign w_sh   = {r_rem, r_low[DIV_QW-1]};
    assign w_ge   = w_sh >= {1'b0, i_dvs};
    assign w_diff = w_sh - {1'b0, i_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= i_mag >= (PROD_W'(i_dvs) << DIV_QW);
            r_rem <= i_mag[DIV_QW +: DIV_DW];
            r_low <= i_mag[DIV_QW-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
            r_low <= {r_low[DIV_QW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_ovf ? {1'b1, {DIV_QW{1'b0}}} : {1'b0, r_low};

endmodule

// ===== tb/sv/tb_keyframed_velocity_path_stepper_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the keyframed velocity path stepper: directed table, random phases
module tb_keyframed_velocity_path_stepper_unit;
    import kvps_pkg::*;

    localparam longint TIME_FLOOR = -64'sd8388608;
    localparam longint S32_MIN    = -64'sd2147483648;
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam int     RANDOM_ITEMS = 800;

    // slave tdata fields, highest first
    typedef struct packed {
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_x;
        logic        [15:0] key_dur;
        logic signed [15:0] key_vel_y;
        logic signed [15:0] key_vel_x;
        logic        [3:0]  slot;
    } t_payload;

    // master tdata fields, highest first
    typedef struct packed {
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_x;
        logic        [3:0]  frame;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_x;
    } t_result;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_val;
        t_cmd        cmd;
        t_payload    pl;
        bit          typed;
        t_result     want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic [119:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [103:0] o_m_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic         i_cfg_wr_en;
    logic [1:0]   i_cfg_index;
    logic [15:0]  i_cfg_wdata;

    keyframed_velocity_path_stepper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic signed [15:0] kf_vel_x [16];
    logic signed [15:0] kf_vel_y [16];
    logic        [15:0] kf_dur [16];
    logic        [4:0]  frame_ptr = '0;
    bit                 frame_started = 1'b0;
    logic signed [23:0] time_rem = '0;
    logic signed [31:0] pos_x_q = '0;
    logic signed [31:0] pos_y_q = '0;
    logic        [4:0]  cfg_frames = 5'd1;
    logic               cfg_loop = 1'b0;
    logic        [15:0] cfg_tick = 16'd256;

    t_result pending_results [$];
    int      mismatch_count = 0;
    bit      calm_phase = 1'b0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_result advance_path(t_cmd cmd, t_payload p);
        t_result r;
        int      cnt;
        int      f;
        int      nxt;
        bit      last;
        longint  dur;
        longint  dx;
        longint  dy;
        longint  num;
        longint  t;
        longint  vx;
        longint  vy;
        r = '0;
        case (cmd)
            CMD_LOAD: begin
                kf_vel_x[p.slot] = p.key_vel_x;
                kf_vel_y[p.slot] = p.key_vel_y;
                kf_dur[p.slot]   = p.key_dur;
            end
            CMD_RESTART: begin
                frame_ptr     = '0;
                frame_started = 1'b0;
                time_rem      = '0;
            end
            CMD_SET: begin
                pos_x_q = p.coord_x;
                pos_y_q = p.coord_y;
            end
            CMD_TICK: begin
                cnt = (cfg_frames == 0) ? 1 : ((cfg_frames > 16) ? 16 : int'(cfg_frames));
                // frame used up: step to the next one and add its duration
                if (time_rem <= 0) begin
                    if (!frame_started) begin
                        frame_ptr     = '0;
                        frame_started = 1'b1;
                    end else begin
                        frame_ptr = frame_ptr + 5'd1;
                    end
                    if (frame_ptr >= cnt) frame_ptr = cfg_loop ? 5'd0 : 5'(cnt - 1);
                    f    = frame_ptr;
                    last = (f + 1 >= cnt);
                    dur  = (last && !cfg_loop) ? longint'(ONE_Q88) : longint'(kf_dur[f]);
                    time_rem = 24'(clamp(longint'(time_rem) + dur, TIME_FLOOR, 65535));
                end
                f    = frame_ptr;
                last = (f + 1 >= cnt);
                if (last && !cfg_loop) begin
                    dur = longint'(ONE_Q88);
                    dx  = 0;
                    dy  = 0;
                end else begin
                    nxt = last ? 0 : f + 1;
                    dur = longint'(kf_dur[f]);
                    dx  = longint'(kf_vel_x[nxt]) - longint'(kf_vel_x[f]);
                    dy  = longint'(kf_vel_y[nxt]) - longint'(kf_vel_y[f]);
                end
                if (dur == 0) dur = 1;
                t   = time_rem;
                num = dur - t;
                vx  = clamp(longint'(kf_vel_x[f]) + (num * dx) / dur, -32768, 32767);
                vy  = clamp(longint'(kf_vel_y[f]) + (num * dy) / dur, -32768, 32767);
                pos_x_q  = 32'(clamp(longint'(pos_x_q) + vx * longint'(cfg_tick),
                                     S32_MIN, S32_MAX));
                pos_y_q  = 32'(clamp(longint'(pos_y_q) + vy * longint'(cfg_tick),
                                     S32_MIN, S32_MAX));
                time_rem = 24'(clamp(t - longint'(cfg_tick), TIME_FLOOR, 65535));
                r.rel_x  = 32'(clamp(longint'(pos_x_q) - longint'(p.coord_x), S32_MIN, S32_MAX));
                r.rel_y  = 32'(clamp(longint'(pos_y_q) - longint'(p.coord_y), S32_MIN, S32_MAX));
                r.vel_x  = 16'(vx);
                r.vel_y  = 16'(vy);
            end
        endcase
        r.frame = frame_started ? frame_ptr[3:0] : 4'd0;
        return r;
    endfunction

    task automatic log_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 50) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) log_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_result(t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            log_mismatch($sformatf("result %h with nothing pending", got));
        end else begin
            want = pending_results.pop_front();
            check_field("rel_x", got.rel_x, want.rel_x);
            check_field("rel_y", got.rel_y, want.rel_y);
            check_field("current_frame", got.frame, want.frame);
            check_field("cur_vel_x", got.vel_x, want.vel_x);
            check_field("cur_vel_y", got.vel_y, want.vel_y);
        end
    endtask

    function automatic int idle_len();
        int r;
        if (calm_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_vel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        if (r < 6) return 16'($urandom_range(0, 1023) - 512);
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7FFF_FFFF;
        if (r == 1) return 32'h8000_0000;
        if (r < 6) return 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
        return $urandom;
    endfunction

    function automatic t_payload rand_payload();
        t_payload p;
        p.slot      = $urandom_range(0, 15);
        p.key_vel_x = rand_vel();
        p.key_vel_y = rand_vel();
        case ($urandom_range(0, 19))
            0:       p.key_dur = '0;
            1, 2:    p.key_dur = $urandom_range(1, 65535);
            default: p.key_dur = $urandom_range(32, 1536);
        endcase
        p.coord_x = rand_coord();
        p.coord_y = rand_coord();
        return p;
    endfunction

    function automatic t_row cmd_row(t_cmd c, logic [3:0] slot, logic [15:0] vx,
                                     logic [15:0] vy, logic [15:0] dur,
                                     logic [31:0] cx, logic [31:0] cy);
        t_row r;
        r.is_cfg       = 1'b0;
        r.cfg_idx      = '0;
        r.cfg_val      = '0;
        r.cmd          = c;
        r.pl.slot      = slot;
        r.pl.key_vel_x = vx;
        r.pl.key_vel_y = vy;
        r.pl.key_dur   = dur;
        r.pl.coord_x   = cx;
        r.pl.coord_y   = cy;
        r.typed        = 1'b0;
        r.want         = '0;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [15:0] val);
        t_row r;
        r         = cmd_row(CMD_LOAD, 4'd0, '0, '0, '0, '0, '0);
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic t_row known(t_row r, t_result w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    task automatic push_command(t_cmd cmd, t_payload p, bit typed, t_result want);
        int      gap;
        t_result predicted;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {4'b0, p};
        i_s_tuser  <= cmd;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = advance_path(cmd, p);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FRAME_COUNT:   cfg_frames = val[4:0];
            CFG_LOOP_ENABLE:   cfg_loop   = val[0];
            CFG_TICK_INTERVAL: cfg_tick   = val;
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int stall;
        int hold;
        i_m_tready = 1'b0;
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            hold = $urandom_range(1, 8);
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) check_result(o_m_tdata[99:0]);
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_row     dir_rows [$];
        t_payload p;
        t_cmd     cmd;
        int       sent;
        int       phase;
        int       n;
        int       r;
        int       guard;
        bit       drift;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_LOAD;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        foreach (kf_dur[i]) begin
            kf_vel_x[i] = '0;
            kf_vel_y[i] = '0;
            kf_dur[i]   = '0;
        end

        // reset defaults: one frame, no loop, tick of 1.0
        dir_rows.push_back(known(cmd_row(CMD_RESTART, 4'd0, '0, '0, '0, '0, '0), '0));
        dir_rows.push_back(known(cmd_row(CMD_LOAD, 4'd0, 16'h7FFF, 16'h8000, 16'hFFFF,
                                         '0, '0), '0));
        dir_rows.push_back(known(cmd_row(CMD_LOAD, 4'd1, 16'h8000, 16'h7FFF, 16'h0001,
                                         '0, '0), '0));
        // zero duration slot
        dir_rows.push_back(known(cmd_row(CMD_LOAD, 4'd2, 16'h0100, 16'hFF00, 16'h0000,
                                         '0, '0), '0));
        dir_rows.push_back(known(cmd_row(CMD_LOAD, 4'd3, 16'h0000, 16'h0040, 16'h0200,
                                         '0, '0), '0));
        dir_rows.push_back(known(cmd_row(CMD_SET, 4'd0, '0, '0, '0, 32'h7FFF_FFFF,
                                         32'h8000_0000), '0));
        // position and relative position both saturate
        dir_rows.push_back(known(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, 32'h8000_0000,
                                         32'h7FFF_FFFF),
                                 t_result'{vel_y: 16'sh8000, vel_x: 16'sh7FFF, frame: 4'd0,
                                           rel_y: 32'sh8000_0000, rel_x: 32'sh7FFF_FFFF}));
        dir_rows.push_back(known(cmd_row(CMD_SET, 4'd0, '0, '0, '0, '0, '0), '0));
        dir_rows.push_back(cfg_row(CFG_FRAME_COUNT, 16'd4));
        dir_rows.push_back(cfg_row(CFG_LOOP_ENABLE, 16'd1));
        dir_rows.push_back(cfg_row(CFG_TICK_INTERVAL, 16'hFFFF));
        dir_rows.push_back(known(cmd_row(CMD_RESTART, 4'd0, '0, '0, '0, '0, '0), '0));
        // walk all four frames, through the zero duration one, and wrap
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, '0, '0));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, 32'h0001_0000, 32'hFFFF_0000));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, 32'h1234_5678, 32'hEDCB_A988));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, '0, '0));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, '0, '0));
        // a frame count of zero acts as one
        dir_rows.push_back(cfg_row(CFG_FRAME_COUNT, 16'd0));
        dir_rows.push_back(cfg_row(CFG_LOOP_ENABLE, 16'd0));
        dir_rows.push_back(cfg_row(CFG_TICK_INTERVAL, 16'd1));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, '0, '0));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, 32'hFFFF_FF00, 32'h0000_0100));
        dir_rows.push_back(cmd_row(CMD_SET, 4'd0, '0, '0, '0, 32'h0000_0100, '0));
        dir_rows.push_back(cmd_row(CMD_TICK, 4'd0, '0, '0, '0, '0, 32'h0000_0100));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                settle();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                push_command(dir_rows[i].cmd, dir_rows[i].pl, dir_rows[i].typed,
                             dir_rows[i].want);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            calm_phase = ($urandom_range(0, 3) == 0);
            drift      = (phase == 3);
            if (drift) begin
                // long run on the held last frame drives time to its floor and can saturate position
                write_reg(CFG_FRAME_COUNT, 16'd1);
                write_reg(CFG_LOOP_ENABLE, 16'd0);
                write_reg(CFG_TICK_INTERVAL, 16'hFFFF);
                n = 160;
            end else begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_FRAME_COUNT, 16'd0);
                    1:       write_reg(CFG_FRAME_COUNT, 16'd31);
                    2:       write_reg(CFG_FRAME_COUNT, 16'd16);
                    3:       write_reg(CFG_FRAME_COUNT, 16'd1);
                    default: write_reg(CFG_FRAME_COUNT, 16'($urandom_range(2, 8)));
                endcase
                write_reg(CFG_LOOP_ENABLE, 16'($urandom_range(0, 1)));
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_TICK_INTERVAL, 16'd1);
                    1:       write_reg(CFG_TICK_INTERVAL, 16'hFFFF);
                    2:       write_reg(CFG_TICK_INTERVAL, 16'($urandom_range(1, 65535)));
                    default: write_reg(CFG_TICK_INTERVAL, 16'($urandom_range(16, 384)));
                endcase
                n = $urandom_range(40, 120);
            end
            // every slot gets loaded before any tick can read it
            if (phase == 0) begin
                for (int s = 0; s < 16; s++) begin
                    p      = rand_payload();
                    p.slot = s;
                    push_command(CMD_LOAD, p, 1'b0, '0);
                    sent++;
                end
            end
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (drift) cmd = (r < 5) ? CMD_SET : CMD_TICK;
                else if (r < 8) cmd = CMD_RESTART;
                else if (r < 20) cmd = CMD_LOAD;
                else if (r < 28) cmd = CMD_SET;
                else cmd = CMD_TICK;
                push_command(cmd, rand_payload(), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/kvps_pkg.sv
src/kvps_div.sv
src/keyframed_velocity_path_stepper_unit.sv
tb/sv/tb_keyframed_velocity_path_stepper_unit.sv
